// ----- src/b64d_pkg.sv -----
// shared types, codes and helper functions for the base64 stream decoder
// no dependencies; used by b64d_core, b64d_outq and base64_stream_decoder_unit
package b64d_pkg;

    // result status codes
    localparam logic [2:0] ST_DATA      = 3'd0;
    localparam logic [2:0] ST_OK        = 3'd1;
    localparam logic [2:0] ST_AFTER_PAD = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_LIMIT     = 3'd4;
    localparam logic [2:0] ST_TRUNC     = 3'd5;

    // input item kinds
    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // padding character
    localparam logic [7:0] CHAR_PAD = 8'h3D;

    // reset value of the decoded byte limit (32 MiB)
    localparam logic [31:0] LIMIT_RESET = 32'd33554432;

    // most results a single input item can cause
    localparam int MAX_RES = 3;

    // default depth of the output queue
    localparam int OUTQ_DEPTH = 8;

    // one result item
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] data_byte;
        logic       last;
    } b64d_res_t;

    // results produced by one accepted item, res[0] goes out first
    typedef struct packed {
        logic [1:0]                   num;
        b64d_res_t [MAX_RES-1:0]      res;
    } b64d_push_t;

    // sextet value of a character: {valid, value}
    function automatic logic [6:0] sextet(input logic [7:0] c);
        logic [7:0] d;
        logic [6:0] r;
        begin
            d = 8'd0;
            r = 7'd0;
            if (c >= 8'h41 && c <= 8'h5A) begin
                d = c - 8'h41;
                r = {1'b1, d[5:0]};
            end else if (c >= 8'h61 && c <= 8'h7A) begin
                d = c - 8'h61 + 8'd26;
                r = {1'b1, d[5:0]};
            end else if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30 + 8'd52;
                r = {1'b1, d[5:0]};
            end else if (c == 8'h2B) begin
                r = {1'b1, 6'd62};
            end else if (c == 8'h2F) begin
                r = {1'b1, 6'd63};
            end
            return r;
        end
    endfunction

    // whitespace that the decoder skips
    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D) || (c == 8'h85) || (c == 8'hA0);
    endfunction

endpackage

// ----- src/b64d_core.sv -----
// decode state and per-character decode logic of the base64 stream decoder
// depends on b64d_pkg; feeds its results to b64d_outq
module b64d_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  logic                 req_type,
    input  logic [7:0]           char_code,
    input  logic                 cfg_we,
    input  logic [31:0]          cfg_wdata,
    output b64d_pkg::b64d_push_t push
);

    // decode state
    logic [5:0]  store0_reg, store0_next;
    logic [5:0]  store1_reg, store1_next;
    logic [5:0]  store2_reg, store2_next;
    logic        pad3_reg, pad3_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [31:0] bytes_reg, bytes_next;
    logic        pad_done_reg, pad_done_next;
    logic [2:0]  err_reg, err_next;
    logic        bad_reg, bad_next;
    logic [31:0] limit_reg;

    // character decode terms
    logic [6:0]  sx;
    logic        pad_char;
    logic [5:0]  v_cur;
    logic [5:0]  v3;
    logic [7:0]  b0, b1, b2;
    logic [1:0]  n;
    logic [32:0] total;
    logic [2:0]  end_status;

    assign sx       = b64d_pkg::sextet(char_code);
    assign pad_char = (char_code == b64d_pkg::CHAR_PAD);
    assign v_cur    = sx[6] ? sx[5:0] : 6'd0;
    assign v3       = pad_char ? 6'd0 : v_cur;

    // bytes of a completed group
    assign b0 = {store0_reg, store1_reg[5:4]};
    assign b1 = {store1_reg[3:0], store2_reg[5:2]};
    assign b2 = {store2_reg[1:0], v3};
    assign n  = !pad_char ? 2'd3 : (pad3_reg ? 2'd1 : 2'd2);

    // group size against the running total
    assign total = {1'b0, bytes_reg} + {31'd0, n};

    // status reported by an end item
    assign end_status = (err_reg != b64d_pkg::ST_DATA) ? err_reg :
                        ((cnt_reg != 2'd0) ? b64d_pkg::ST_TRUNC : b64d_pkg::ST_OK);

    // next state and results for one transfer
    always_comb begin
        store0_next   = store0_reg;
        store1_next   = store1_reg;
        store2_next   = store2_reg;
        pad3_next     = pad3_reg;
        cnt_next      = cnt_reg;
        bytes_next    = bytes_reg;
        pad_done_next = pad_done_reg;
        err_next      = err_reg;
        bad_next      = bad_reg;
        push          = '0;
        if (item_valid) begin
            if (req_type == b64d_pkg::REQ_END) begin
                push.num               = 2'd1;
                push.res[0].status     = end_status;
                push.res[0].data_byte  = 8'd0;
                push.res[0].last       = 1'b1;
                store0_next   = 6'd0;
                store1_next   = 6'd0;
                store2_next   = 6'd0;
                pad3_next     = 1'b0;
                cnt_next      = 2'd0;
                bytes_next    = 32'd0;
                pad_done_next = 1'b0;
                err_next      = b64d_pkg::ST_DATA;
                bad_next      = 1'b0;
            end else if (err_reg != b64d_pkg::ST_DATA || b64d_pkg::is_blank(char_code)) begin
                // skipped
            end else if (pad_done_reg) begin
                err_next = b64d_pkg::ST_AFTER_PAD;
            end else if (cnt_reg != 2'd3) begin
                // first three characters of a group are only held
                if (cnt_reg == 2'd2 && pad_char) begin
                    pad3_next = 1'b1;
                end else if (!sx[6]) begin
                    bad_next = 1'b1;
                end
                case (cnt_reg)
                    2'd0:    store0_next = v_cur;
                    2'd1:    store1_next = v_cur;
                    default: store2_next = (pad_char) ? 6'd0 : v_cur;
                endcase
                cnt_next = cnt_reg + 2'd1;
            end else if (bad_reg || (!pad_char && !sx[6]) || (pad3_reg && !pad_char)) begin
                err_next = b64d_pkg::ST_INVALID;
            end else if (total > {1'b0, limit_reg}) begin
                err_next = b64d_pkg::ST_LIMIT;
            end else begin
                // emit the group
                push.num              = n;
                push.res[0].status    = b64d_pkg::ST_DATA;
                push.res[0].data_byte = b0;
                push.res[0].last      = (n == 2'd1);
                push.res[1].status    = b64d_pkg::ST_DATA;
                push.res[1].data_byte = b1;
                push.res[1].last      = (n == 2'd2);
                push.res[2].status    = b64d_pkg::ST_DATA;
                push.res[2].data_byte = b2;
                push.res[2].last      = 1'b1;
                bytes_next    = total[31:0];
                pad_done_next = pad3_reg || pad_char;
                cnt_next      = 2'd0;
                pad3_next     = 1'b0;
                bad_next      = 1'b0;
                store0_next   = 6'd0;
                store1_next   = 6'd0;
                store2_next   = 6'd0;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store0_reg   <= 6'd0;
            store1_reg   <= 6'd0;
            store2_reg   <= 6'd0;
            pad3_reg     <= 1'b0;
            cnt_reg      <= 2'd0;
            bytes_reg    <= 32'd0;
            pad_done_reg <= 1'b0;
            err_reg      <= b64d_pkg::ST_DATA;
            bad_reg      <= 1'b0;
        end else begin
            store0_reg   <= store0_next;
            store1_reg   <= store1_next;
            store2_reg   <= store2_next;
            pad3_reg     <= pad3_next;
            cnt_reg      <= cnt_next;
            bytes_reg    <= bytes_next;
            pad_done_reg <= pad_done_next;
            err_reg      <= err_next;
            bad_reg      <= bad_next;
        end
    end

    // limit register, kept across end items
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= b64d_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    // a held bad character implies a partly filled group
    a_bad_in_group: assert property (@(posedge aclk) disable iff (!aresetn)
        bad_reg |-> (cnt_reg != 2'd0))
        else $error("bad character flag set with empty group");

    // after a padded group no characters are gathered
    a_pad_done_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pad_done_reg |-> (cnt_reg == 2'd0))
        else $error("characters gathered after padding");

    // an end item clears the error and the group
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && req_type == b64d_pkg::REQ_END) |=>
            (err_reg == b64d_pkg::ST_DATA && cnt_reg == 2'd0 && bytes_reg == 32'd0))
        else $error("end item did not clear state");

endmodule

// ----- src/b64d_outq.sv -----
// output queue of the base64 stream decoder: takes up to three results per cycle,
// hands out one per cycle while out_ready is high; depends on b64d_pkg
module b64d_outq #(
    parameter int DEPTH = b64d_pkg::OUTQ_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  b64d_pkg::b64d_push_t push,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output b64d_pkg::b64d_res_t  out_res
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    b64d_pkg::b64d_res_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    // pointer advance with wrap at the queue depth
    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [1:0] k);
        logic [PW:0] s;
        begin
            s = {1'b0, p} + {{(PW-1){1'b0}}, k};
            if (s >= (PW+1)'(DEPTH)) begin
                s = s - (PW+1)'(DEPTH);
            end
            return s[PW-1:0];
        end
    endfunction

    assign out_valid = (count_reg != '0);
    assign out_res   = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= CW'(DEPTH - b64d_pkg::MAX_RES));

    // pointers and fill level
    always_comb begin
        wr_ptr_next = adv(wr_ptr_reg, push.num);
        rd_ptr_next = adv(rd_ptr_reg, {1'b0, pop});
        count_next  = count_reg + CW'(push.num) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage writes, results of one item in order
    always_ff @(posedge aclk) begin
        for (int k = 0; k < b64d_pkg::MAX_RES; k++) begin
            if (2'(k) < push.num) begin
                mem[adv(wr_ptr_reg, 2'(k))] <= push.res[k];
            end
        end
    end

    // fill level stays within the depth
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("output queue overflow");

    // results only arrive when room for a full group is there
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.num != 2'd0) |-> room)
        else $error("results pushed without room");

endmodule

// ----- src/base64_stream_decoder_unit.sv -----
// top level of the base64 stream decoder: stream ports, decode core, output queue
// depends on b64d_pkg, b64d_core and b64d_outq
//
// Strict Base64 decoder taking one Latin-1 character per input transfer (s_tuser = 0)
// or an end marker (s_tuser = 1). Whitespace is skipped; every fourth significant
// character completes a group and pushes one to three decoded bytes (status 0) into an
// output queue; an end marker pushes one status result (ok, truncated or the first
// error) and clears the decode state, but not the byte limit. Each input transfer is
// decoded in the cycle it is accepted, so one character is taken per cycle and its results
// can leave from the next cycle on, one per cycle. s_tready is low while the output queue
// (OUTQ_DEPTH entries) has fewer than three free slots, so the sustained rate is one
// character per cycle as long as m_tready keeps up with three bytes per four characters.
// The user must write the byte limit through cfg_we / cfg_wdata only while idle; the block does not enforce it.
module base64_stream_decoder_unit #(
    parameter int OUTQ_DEPTH = b64d_pkg::OUTQ_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic [0:0]  s_tuser,   // [0] req_type
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_byte
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast,
    // limit register write
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    b64d_pkg::b64d_push_t push;
    b64d_pkg::b64d_res_t  out_res;
    logic                 room;
    logic                 item_valid;

    // an input transfer completes here
    assign s_tready   = room;
    assign item_valid = s_tvalid && room;

    b64d_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .req_type   (s_tuser[0]),
        .char_code  (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push       (push)
    );

    b64d_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // result fields onto the stream ports
    assign m_tdata = out_res.data_byte;
    assign m_tuser = out_res.status;
    assign m_tlast = out_res.last;

endmodule

// ----- bench/tb.sv -----
// self-checking bench for base64_stream_decoder_unit: stream driver, monitor, decode predictor
// depends on b64d_pkg and the decoder RTL; needs no files or arguments at run time
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one input transfer: kind and character
    typedef struct packed {
        logic       req;
        logic [7:0] ch;
    } char_item_t;

    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 47;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 100;
    localparam int HOLD_AFTER    = 60;
    localparam int WATCHDOG_MAX  = 1000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic [0:0]  s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = 32'd0;

    char_item_t            char_queue[$];
    b64d_pkg::b64d_res_t   dec_expect[$];

    int n_queued = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_settings = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;

    // predictor copy of the decode state and the limit register
    logic [5:0]  grp_store[3];
    logic        grp_pad3;
    int          grp_count;
    logic [31:0] bytes_out;
    logic        pad_done;
    logic [2:0]  sticky_err;
    logic        grp_bad;
    logic [31:0] byte_limit;

    base64_stream_decoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [7:0] char_code
        .s_tuser   (s_tuser),     // [0] req_type
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [7:0] data_byte
        .m_tuser   (m_tuser),     // [2:0] status
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // value of a base64 alphabet character, -1 when outside the alphabet
    function automatic int sextet_val(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return int'(c) - int'("A");
        if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
        if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
        if (c == "+") return 62;
        if (c == "/") return 63;
        return -1;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D) || c == 8'h85 || c == 8'hA0;
    endfunction

    // alphabet character for a sextet value
    function automatic logic [7:0] b64_char(input int v);
        if (v < 26) return 8'(int'("A") + v);
        if (v < 52) return 8'(int'("a") + v - 26);
        if (v < 62) return 8'(int'("0") + v - 52);
        if (v == 62) return "+";
        return "/";
    endfunction

    function automatic void clear_decode();
        grp_store[0] = 6'd0;
        grp_store[1] = 6'd0;
        grp_store[2] = 6'd0;
        grp_pad3 = 1'b0;
        grp_count = 0;
        bytes_out = 32'd0;
        pad_done = 1'b0;
        sticky_err = b64d_pkg::ST_DATA;
        grp_bad = 1'b0;
    endfunction

    function automatic void push_result(input logic [2:0] st, input logic [7:0] b,
                                        input logic lst);
        b64d_pkg::b64d_res_t r;
        r.status = st;
        r.data_byte = b;
        r.last = lst;
        dec_expect.push_back(r);
    endfunction

    // predicted results of one accepted transfer
    function automatic void decode_item(input logic req, input logic [7:0] c);
        int v;
        int n;
        logic pad4;
        logic [5:0] v3;
        logic [7:0] b[3];
        if (req == b64d_pkg::REQ_END) begin
            if (sticky_err != b64d_pkg::ST_DATA) push_result(sticky_err, 8'd0, 1'b1);
            else if (grp_count != 0) push_result(b64d_pkg::ST_TRUNC, 8'd0, 1'b1);
            else push_result(b64d_pkg::ST_OK, 8'd0, 1'b1);
            clear_decode();
            return;
        end
        if (sticky_err != b64d_pkg::ST_DATA || is_space(c)) return;
        if (pad_done) begin
            sticky_err = b64d_pkg::ST_AFTER_PAD;
            return;
        end
        // first three characters are only collected
        if (grp_count < 3) begin
            v = sextet_val(c);
            if (grp_count == 2 && c == b64d_pkg::CHAR_PAD) begin
                grp_pad3 = 1'b1;
                v = 0;
            end else if (v < 0) begin
                grp_bad = 1'b1;
                v = 0;
            end
            grp_store[grp_count] = v[5:0];
            grp_count++;
            return;
        end
        // fourth character closes the group
        pad4 = (c == b64d_pkg::CHAR_PAD);
        v3 = 6'd0;
        if (!pad4) begin
            v = sextet_val(c);
            if (v < 0) grp_bad = 1'b1;
            else v3 = v[5:0];
        end
        if (grp_bad || (grp_pad3 && !pad4)) begin
            sticky_err = b64d_pkg::ST_INVALID;
            return;
        end
        b[0] = {grp_store[0], grp_store[1][5:4]};
        b[1] = {grp_store[1][3:0], grp_store[2][5:2]};
        b[2] = {grp_store[2][1:0], v3};
        n = pad4 ? (grp_pad3 ? 1 : 2) : 3;
        if (33'(bytes_out) + 33'(n) > 33'(byte_limit)) begin
            sticky_err = b64d_pkg::ST_LIMIT;
            return;
        end
        for (int k = 0; k < n; k++) push_result(b64d_pkg::ST_DATA, b[k], k == n - 1);
        bytes_out = bytes_out + 32'(n);
        pad_done = grp_pad3 || pad4;
        grp_count = 0;
        grp_pad3 = 1'b0;
        grp_bad = 1'b0;
        grp_store[0] = 6'd0;
        grp_store[1] = 6'd0;
        grp_store[2] = 6'd0;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at result %0d", what, got, want, n_results);
        n_errors++;
    endtask

    // input side: present queued characters, predict on each transfer
    always @(posedge aclk) begin : tx_side
        int gap;
        char_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_item(s_tuser[0], s_tdata);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap > 0) begin
                    gap--;
                    s_tvalid <= 1'b0;
                end else if (char_queue.size() != 0) begin
                    it = char_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= it.req;
                    s_tdata <= it.ch;
                    if (!calm && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 5);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side: compare each transfer, stall at random, one long hold-off
    always @(posedge aclk) begin : rx_side
        int stall;
        int hold_left;
        bit hold_done;
        b64d_pkg::b64d_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (dec_expect.size() == 0) begin
                    report_mismatch("result with none expected", m_tuser, -1);
                end else begin
                    want = dec_expect.pop_front();
                    if (m_tuser !== want.status) report_mismatch("status", m_tuser, want.status);
                    if (m_tdata !== want.data_byte)
                        report_mismatch("data_byte", m_tdata, want.data_byte);
                    if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
                end
            end
            if (!hold_done && n_accepted >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 5);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("timeout after %0d cycles without a transfer", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic queue_item(input logic req, input logic [7:0] c);
        char_item_t it;
        it.req = req;
        it.ch = c;
        char_queue.push_back(it);
        n_queued++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_item(b64d_pkg::REQ_CHAR, s[i]);
    endtask

    // one encoded stream closed by an end marker, mostly well formed
    task automatic queue_stream(output int count);
        logic [7:0] seq[$];
        logic [7:0] blanks[8];
        int ng;
        int mode;
        int pos;
        int start_count;
        blanks = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h85, 8'hA0};
        start_count = n_queued;
        ng = $urandom_range(0, 4);
        mode = $urandom_range(0, 9);
        if (mode == 9) begin
            // raw noise over the full byte range
            repeat ($urandom_range(1, 12)) seq.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat (ng * 4) seq.push_back(b64_char($urandom_range(0, 63)));
            if (ng > 0) begin
                case ($urandom_range(0, 3))
                    2: seq[seq.size() - 1] = b64d_pkg::CHAR_PAD;
                    3: begin
                        seq[seq.size() - 1] = b64d_pkg::CHAR_PAD;
                        seq[seq.size() - 2] = b64d_pkg::CHAR_PAD;
                    end
                    default: ;
                endcase
            end
            // broken streams
            if (mode == 8 && seq.size() > 0) begin
                pos = $urandom_range(0, seq.size() - 1);
                case ($urandom_range(0, 3))
                    0: seq[pos] = 8'($urandom_range(0, 255));
                    1: void'(seq.pop_back());
                    2: seq.push_back(b64_char($urandom_range(0, 63)));
                    default: begin
                        seq[seq.size() - 2] = b64d_pkg::CHAR_PAD;
                        seq[seq.size() - 1] = b64_char($urandom_range(0, 63));
                    end
                endcase
            end else if (mode == 7 && seq.size() > 0) begin
                // pad in the first or second place of a group
                pos = ($urandom_range(0, seq.size() - 1) & ~3) + $urandom_range(0, 1);
                seq[pos] = b64d_pkg::CHAR_PAD;
            end
        end
        foreach (seq[i]) begin
            if ($urandom_range(0, 7) == 0)
                queue_item(b64d_pkg::REQ_CHAR, blanks[$urandom_range(0, 7)]);
            queue_item(b64d_pkg::REQ_CHAR, seq[i]);
        end
        queue_item(b64d_pkg::REQ_END, 8'($urandom_range(0, 255)));
        count = n_queued - start_count;
    endtask

    // wait until every queued transfer is taken and every result has come
    task automatic settle();
        while (n_accepted != n_queued || dec_expect.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        byte_limit = v;
        n_settings++;
    endtask

    // stimulus sequence
    initial begin
        logic [31:0] limits[RAND_PHASES];
        int added;
        int got;
        clear_decode();
        byte_limit = b64d_pkg::LIMIT_RESET;
        limits = '{32'hFFFF_FFFF, 32'd0, 32'd5, 32'd1, $urandom, 32'd3, 32'd12,
                   b64d_pkg::LIMIT_RESET};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: alphabet extremes, a single-pad group, and the after-pad, invalid and truncated cases
        queue_text("+/ z9");
        queue_text("TWE=");
        queue_text("Q");
        queue_item(b64d_pkg::REQ_END, 8'h00);
        queue_text("AB=C");
        queue_item(b64d_pkg::REQ_END, 8'hFF);
        queue_item(b64d_pkg::REQ_CHAR, 8'hFF);
        queue_text("A");
        queue_item(b64d_pkg::REQ_END, 8'h00);
        queue_text("A=AA");
        queue_item(b64d_pkg::REQ_END, 8'h00);
        queue_item(b64d_pkg::REQ_END, 8'h00);
        settle();

        // random phases, one limit setting each, last one without idling
        for (int p = 0; p < RAND_PHASES; p++) begin
            write_limit(limits[p]);
            if (p == RAND_PHASES - 1) calm = 1'b1;
            added = 0;
            while (added < PHASE_ITEMS) begin
                queue_stream(got);
                added += got;
            end
            settle();
        end

        $display("covered %0d input transfers and %0d result transfers", n_accepted, n_results);
        $display("over %0d limit settings with a long output hold-off", n_settings);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
